@@ hdl/pdt_pkg.sv @@
// ----------------------------------------------------------------------------
// pdt_pkg: shared types and constants of the peer discovery table
// Entry and result layouts, control FSM states, register indexes and the
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package pdt_pkg;

  // Fixed field widths
  localparam int unsigned AddrW     = 48;
  localparam int unsigned IdentW    = 64;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned SlotW     = 3;
  localparam int unsigned CountOutW = 4;

  // Default table size
  localparam int unsigned TableDepthDef = 8;

  // Configuration register indexes and reset values
  localparam logic CfgIdxInterval = 1'b0;
  localparam logic CfgIdxTtl      = 1'b1;
  localparam logic [TimeW-1:0] PruneIntervalRst = 32'd1000;
  localparam logic [TimeW-1:0] EntryTtlRst      = 32'd3000;

  // Input item kinds
  localparam logic KindObserve = 1'b0;
  localparam logic KindTick    = 1'b1;

  // One table entry
  typedef struct packed {
    logic [TimeW-1:0]  seen;
    logic [IdentW-1:0] ident;
    logic [AddrW-1:0]  addr;
  } entry_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic load;   // take the broadcast entry
    logic shift;  // take the neighbor's entry
  } cell_ctrl_t;

  // Result beat, hit in bit 0
  typedef struct packed {
    logic [CountOutW-1:0] entry_count;
    logic                 pruned;
    logic [SlotW-1:0]     slot;
    logic                 evicted;
    logic                 hit;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OBS_SCAN,
    ST_OBS_WRITE,
    ST_PRN_SCAN,
    ST_EMIT
  } state_e;

endpackage

@@ hdl/pdt_cell.sv @@
// ----------------------------------------------------------------------------
// pdt_cell: one entry of the peer table
// Holds address, identity and last-seen time; loads the broadcast entry or
// takes over its upper neighbor's entry when the table collapses.
// ----------------------------------------------------------------------------
module pdt_cell (
  input  logic               clk_i,
  input  pdt_pkg::cell_ctrl_t ctrl_i,
  input  pdt_pkg::entry_t    din_i,
  input  pdt_pkg::entry_t    nbr_i,
  output pdt_pkg::entry_t    q_o
);

  pdt_pkg::entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.load) begin
      entry_d = din_i;
    end else if (ctrl_i.shift) begin
      entry_d = nbr_i;
    end else begin
      entry_d = entry_q;
    end
  end

  // Payload only: contents stay undefined until first written
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o = entry_q;

endmodule

@@ hdl/peer_discovery_table_unit.sv @@
// ----------------------------------------------------------------------------
// peer_discovery_table_unit: table of discovered peers with LRU replacement
// and TTL pruning
// A row of entry cells with a scan sequencer. Observe beats refresh, append
// or evict; tick beats prune stale entries and collapse the row in order.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Beat contents (low bit first)
//  --------  ---  ------------------------------------------------------------
//  s_axis    in   tuser: kind; tdata: src_addr, identity_word, now_ms
//  m_axis    out  tdata: hit, evicted, slot, pruned, entry_count, zero fill
//  cfg       in   cfg_idx_i 0 prune interval, 1 entry TTL; cfg_wdata_i value
//
//  Sequence: an observe beat is accepted in idle; the scan then walks the whole
//  row, reading one cell per cycle, then a write and a result state follow. A
//  tick that prunes examines each valid entry, one cell per cycle, then enters
//  the result state; a tick that does not prune goes there directly.
//  Reset clears the valid count, last prune time, sequencer and output; the
//  cell contents stay undefined until written. A stalled output beat holds
//  the sequencer in its result state; one finished result may wait in the
//  output register while the next beat is accepted and worked on.
//
module peer_discovery_table_unit #(
  parameter int unsigned TableDepth = pdt_pkg::TableDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [143:0] s_axis_tdata_i,  // src_addr[47:0], identity_word[111:48],
                                        // now_ms[143:112]
  input  logic [0:0]   s_axis_tuser_i,  // kind[0]
  // Result stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [15:0]  m_axis_tdata_o,  // hit[0], evicted[1], slot[4:2], pruned[5],
                                        // entry_count[9:6], zero[15:10]
  // Configuration writes
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);

  localparam int unsigned IdxW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW      = $clog2(TableDepth + 1);
  localparam int unsigned TimeW     = pdt_pkg::TimeW;
  localparam int unsigned SlotW     = pdt_pkg::SlotW;
  localparam int unsigned CountOutW = pdt_pkg::CountOutW;
  localparam int unsigned ResultW   = pdt_pkg::ResultW;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(TableDepth);

  // --------------------------------------------------------------------------
  // Input unpacking
  // --------------------------------------------------------------------------
  pdt_pkg::entry_t in_entry;
  logic            in_kind;
  logic            s_acc;

  assign in_entry.addr  = s_axis_tdata_i[47:0];
  assign in_entry.ident = s_axis_tdata_i[111:48];
  assign in_entry.seen  = s_axis_tdata_i[143:112];
  assign in_kind        = s_axis_tuser_i[0];

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  pdt_pkg::state_e  state_q, state_d;
  pdt_pkg::entry_t  item_q, item_d;           // observed peer, now_ms in .seen
  logic [CntW-1:0]  cnt_q, cnt_d;             // valid entries
  logic [TimeW-1:0] last_prune_q, last_prune_d;
  logic [TimeW-1:0] interval_q, ttl_q;
  logic [IdxW-1:0]  idx_q, idx_d;             // observe scan position
  logic             found_q, found_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  logic [IdxW-1:0]  best_q, best_d;           // oldest entry so far
  logic [TimeW-1:0] best_seen_q, best_seen_d;
  logic [CntW-1:0]  w_q, w_d;                 // prune write position
  logic [CntW-1:0]  j_q, j_d;                 // prune read count
  pdt_pkg::result_t res_q, res_d;
  pdt_pkg::result_t out_q, out_d;
  logic             m_valid_q, m_valid_d;

  // --------------------------------------------------------------------------
  // Cell row
  // --------------------------------------------------------------------------
  pdt_pkg::entry_t    cell_q   [TableDepth];
  pdt_pkg::entry_t    cell_nbr [TableDepth];
  pdt_pkg::cell_ctrl_t cell_ctrl [TableDepth];

  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic            collapse;

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    if (i < TableDepth - 1) begin : g_mid
      assign cell_nbr[i] = cell_q[i+1];
    end else begin : g_end
      assign cell_nbr[i] = cell_q[i];
    end

    assign cell_ctrl[i].load  = wr_en && (wr_idx == IdxW'(i));
    assign cell_ctrl[i].shift = collapse && (CntW'(i) >= w_q);

    pdt_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[i]),
      .din_i  (item_q),
      .nbr_i  (cell_nbr[i]),
      .q_o    (cell_q[i])
    );
  end

  // Single read tap: the scan position of whichever pass is running
  logic [IdxW-1:0] rd_idx;
  pdt_pkg::entry_t rd;

  assign rd_idx = (state_q == pdt_pkg::ST_PRN_SCAN) ? w_q[IdxW-1:0] : idx_q;
  assign rd     = cell_q[rd_idx];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic             out_free;
  logic             in_range;
  logic             keep;
  logic [TimeW-1:0] since_prune;

  assign out_free    = !m_valid_q || m_axis_tready_i;
  assign in_range    = CntW'(idx_q) < cnt_q;
  assign keep        = (item_q.seen - rd.seen) <= ttl_q;
  assign since_prune = in_entry.seen - last_prune_q;
  assign s_acc       = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state_q == pdt_pkg::ST_IDLE);

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    cnt_d        = cnt_q;
    last_prune_d = last_prune_q;
    idx_d        = idx_q;
    found_d      = found_q;
    hit_idx_d    = hit_idx_q;
    best_d       = best_q;
    best_seen_d  = best_seen_q;
    w_d          = w_q;
    j_d          = j_q;
    res_d        = res_q;
    out_d        = out_q;
    m_valid_d    = m_valid_q && !m_axis_tready_i;
    wr_en        = 1'b0;
    wr_idx       = '0;
    collapse     = 1'b0;

    unique case (state_q)
      pdt_pkg::ST_IDLE: begin
        if (s_acc) begin
          item_d = in_entry;
          res_d  = '0;
          if (in_kind == pdt_pkg::KindObserve) begin
            idx_d   = '0;
            found_d = 1'b0;
            state_d = pdt_pkg::ST_OBS_SCAN;
          end else if (since_prune >= interval_q) begin
            last_prune_d = in_entry.seen;
            res_d.pruned = 1'b1;
            w_d          = '0;
            j_d          = '0;
            if (cnt_q == '0) begin
              res_d.entry_count = '0;
              state_d           = pdt_pkg::ST_EMIT;
            end else begin
              state_d = pdt_pkg::ST_PRN_SCAN;
            end
          end else begin
            res_d.entry_count = CountOutW'(cnt_q);
            state_d           = pdt_pkg::ST_EMIT;
          end
        end
      end

      pdt_pkg::ST_OBS_SCAN: begin
        // First match among valid entries wins
        if (!found_q && in_range && (rd.addr == item_q.addr)) begin
          found_d   = 1'b1;
          hit_idx_d = idx_q;
        end
        // Oldest by raw seen value, lowest index on a tie
        if ((idx_q == '0) || (rd.seen < best_seen_q)) begin
          best_d      = idx_q;
          best_seen_d = rd.seen;
        end
        if (idx_q == LastIdx) begin
          state_d = pdt_pkg::ST_OBS_WRITE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      pdt_pkg::ST_OBS_WRITE: begin
        wr_en = 1'b1;
        priority if (found_q) begin
          wr_idx    = hit_idx_q;
          res_d.hit = 1'b1;
        end else if (cnt_q != FullCnt) begin
          wr_idx = cnt_q[IdxW-1:0];
          cnt_d  = cnt_q + 1'b1;
        end else begin
          wr_idx        = best_q;
          res_d.evicted = 1'b1;
        end
        res_d.slot        = SlotW'(wr_idx);
        res_d.entry_count = CountOutW'(cnt_d);
        state_d           = pdt_pkg::ST_EMIT;
      end

      pdt_pkg::ST_PRN_SCAN: begin
        // Keep: advance the write position; drop: collapse the row onto it
        if (keep) begin
          w_d = w_q + 1'b1;
        end else begin
          collapse = 1'b1;
        end
        j_d = j_q + 1'b1;
        if (j_d == cnt_q) begin
          cnt_d             = w_d;
          res_d.entry_count = CountOutW'(w_d);
          state_d           = pdt_pkg::ST_EMIT;
        end
      end

      pdt_pkg::ST_EMIT: begin
        if (out_free) begin
          out_d     = res_q;
          m_valid_d = 1'b1;
          state_d   = pdt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = pdt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pdt_pkg::ST_IDLE;
      cnt_q        <= '0;
      last_prune_q <= '0;
      idx_q        <= '0;
      found_q      <= 1'b0;
      hit_idx_q    <= '0;
      best_q       <= '0;
      best_seen_q  <= '0;
      w_q          <= '0;
      j_q          <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      last_prune_q <= last_prune_d;
      idx_q        <= idx_d;
      found_q      <= found_d;
      hit_idx_q    <= hit_idx_d;
      best_q       <= best_d;
      best_seen_q  <= best_seen_d;
      w_q          <= w_d;
      j_q          <= j_d;
      m_valid_q    <= m_valid_d;
    end
  end

  // Payload: item, pending result and output beat
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= pdt_pkg::PruneIntervalRst;
      ttl_q      <= pdt_pkg::EntryTtlRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pdt_pkg::CfgIdxInterval: interval_q <= cfg_wdata_i;
        pdt_pkg::CfgIdxTtl:      ttl_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output
  // --------------------------------------------------------------------------
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(16 - ResultW)'(0), out_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Valid count never exceeds the row length
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("valid count above table depth");

  // Collapse never overtakes the read position
  a_prune_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pdt_pkg::ST_PRN_SCAN) |-> (w_q <= j_q) && (j_q < cnt_q))
    else $error("prune positions out of order");

  // An accepted observe beat starts a scan at the first cell
  a_obs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (in_kind == pdt_pkg::KindObserve)) |=>
      (state_q == pdt_pkg::ST_OBS_SCAN) && (idx_q == '0))
    else $error("observe scan did not start");

  // A result never reports both a hit and an eviction, nor a prune with them
  a_res_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(out_q.hit && out_q.evicted) &&
                  !(out_q.pruned && (out_q.hit || out_q.evicted)))
    else $error("conflicting result flags");

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the peer discovery table
// Drives observe and tick beats into peer_discovery_table_unit, predicts every
// result beat with an independent table model, and compares the result
// stream field by field. Covers append, refresh, eviction with ties, pruning
// with compaction, wrapping time, and several prune interval and TTL settings,
// under random back-pressure and source gaps.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AddrW      = pdt_pkg::AddrW;
  localparam int unsigned IdentW     = pdt_pkg::IdentW;
  localparam int unsigned TimeW      = pdt_pkg::TimeW;
  localparam int unsigned SlotW      = pdt_pkg::SlotW;
  localparam int unsigned CountOutW  = pdt_pkg::CountOutW;
  localparam int unsigned ResultW    = pdt_pkg::ResultW;
  localparam int unsigned TableDepth = pdt_pkg::TableDepthDef;
  localparam int unsigned PoolSize   = 12;      // more peers than slots: forces evictions
  localparam int unsigned DrainWait  = 2 * TableDepth + 8;
  localparam int unsigned HoldCycles = 400;     // long receiver stall
  localparam int unsigned CycleLimit = 300000;

  // --------------------------------------------------------------------------
  // Table model and result checker
  // --------------------------------------------------------------------------
  class peer_table_tracker;
    logic [AddrW-1:0]  tab_addr  [TableDepth];
    logic [IdentW-1:0] tab_ident [TableDepth];
    logic [TimeW-1:0]  tab_seen  [TableDepth];
    int unsigned       live_entries;
    logic [TimeW-1:0]  last_prune;
    logic [TimeW-1:0]  prune_interval;
    logic [TimeW-1:0]  entry_ttl;
    pdt_pkg::result_t  expected_results[$];
    int unsigned       mismatches;
    int unsigned       beats_checked;

    function new();
      live_entries   = 0;
      last_prune     = '0;
      prune_interval = pdt_pkg::PruneIntervalRst;
      entry_ttl      = pdt_pkg::EntryTtlRst;
      mismatches     = 0;
      beats_checked  = 0;
    endfunction

    function void set_reg(logic idx, logic [TimeW-1:0] value);
      if (idx == pdt_pkg::CfgIdxInterval) prune_interval = value;
      else entry_ttl = value;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void put_entry(int unsigned idx, logic [AddrW-1:0] addr,
                            logic [IdentW-1:0] ident, logic [TimeW-1:0] now);
      tab_addr[idx]  = addr;
      tab_ident[idx] = ident;
      tab_seen[idx]  = now;
    endfunction

    // Apply one accepted input beat and queue the result it must produce.
    function void take_item(logic kind, logic [AddrW-1:0] addr,
                            logic [IdentW-1:0] ident, logic [TimeW-1:0] now);
      pdt_pkg::result_t res;
      int               match_idx;
      int unsigned      oldest;
      int unsigned      keep;
      logic [TimeW-1:0] since;
      res = '0;
      if (kind == pdt_pkg::KindObserve) begin
        match_idx = -1;
        for (int unsigned i = 0; i < live_entries; i++) begin
          if (match_idx < 0 && tab_addr[i] == addr) match_idx = int'(i);
        end
        if (match_idx >= 0) begin
          put_entry(unsigned'(match_idx), addr, ident, now);
          res.hit  = 1'b1;
          res.slot = match_idx[SlotW-1:0];
        end else if (live_entries < TableDepth) begin
          put_entry(live_entries, addr, ident, now);
          res.slot = live_entries[SlotW-1:0];
          live_entries++;
        end else begin
          // oldest by raw timestamp, no wrap; lowest index wins a tie
          oldest = 0;
          for (int unsigned i = 1; i < TableDepth; i++) begin
            if (tab_seen[i] < tab_seen[oldest]) oldest = i;
          end
          put_entry(oldest, addr, ident, now);
          res.slot    = oldest[SlotW-1:0];
          res.evicted = 1'b1;
        end
      end else begin
        since = now - last_prune;
        if (since >= prune_interval) begin
          keep = 0;
          for (int unsigned i = 0; i < live_entries; i++) begin
            since = now - tab_seen[i];
            if (since <= entry_ttl) begin
              put_entry(keep, tab_addr[i], tab_ident[i], tab_seen[i]);
              keep++;
            end
          end
          live_entries = keep;
          last_prune   = now;
          res.pruned   = 1'b1;
        end
      end
      res.entry_count = live_entries[CountOutW-1:0];
      expected_results.push_back(res);
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] MISMATCH beat %0d: %s", $time, beats_checked, msg);
    endtask

    task check_result(logic [15:0] beat);
      pdt_pkg::result_t got;
      pdt_pkg::result_t want;
      got = pdt_pkg::result_t'(beat[ResultW-1:0]);
      if (expected_results.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", beat));
        return;
      end
      want = expected_results.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit %b, want %b", got.hit, want.hit));
      if (got.evicted !== want.evicted)
        report($sformatf("evicted %b, want %b", got.evicted, want.evicted));
      if (got.slot !== want.slot)
        report($sformatf("slot %0d, want %0d", got.slot, want.slot));
      if (got.pruned !== want.pruned)
        report($sformatf("pruned %b, want %b", got.pruned, want.pruned));
      if (got.entry_count !== want.entry_count)
        report($sformatf("entry_count %0d, want %0d", got.entry_count, want.entry_count));
      if (beat[15:ResultW] !== '0)
        report($sformatf("fill bits %h not zero", beat[15:ResultW]));
      beats_checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [143:0] s_axis_tdata_i;   // src_addr[47:0], identity_word[111:48], now_ms[143:112]
  logic [0:0]   s_axis_tuser_i;   // kind[0]
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [15:0]  m_axis_tdata_o;   // hit[0], evicted[1], slot[4:2], pruned[5],
                                  // entry_count[9:6], zero[15:10]
  logic         cfg_we_i;
  logic         cfg_idx_i;
  logic [31:0]  cfg_wdata_i;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  peer_discovery_table_unit #(
    .TableDepth(TableDepth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  peer_table_tracker sb;

  logic [AddrW-1:0] peer_pool[PoolSize];
  logic [TimeW-1:0] clock_now;
  bit               calm;           // no idling on either side in the final phase
  bit               hold_off_req;   // ask the sink for one long stall

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    return AddrW'(rand64());
  endfunction

  // --------------------------------------------------------------------------
  // Monitors: sample both streams at the rising edge
  // --------------------------------------------------------------------------
  // Predict on every accepted input beat, straight from the port.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      sb.take_item(s_axis_tuser_i[0], s_axis_tdata_i[47:0], s_axis_tdata_i[111:48],
                   s_axis_tdata_i[143:112]);
  end

  // Compare every accepted result beat against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o);
  end

  // Watchdog: fail and end the run if the sequence has not finished by CycleLimit.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result sink: random stall bursts, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        // drop ready for a long stretch so the table backs up into the input
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  // Offer one beat at the falling edge and hold it until accepted. Valid stays
  // high afterwards so back-to-back beats keep valid asserted between them.
  task automatic send_fields(logic kind, logic [AddrW-1:0] addr, logic [IdentW-1:0] ident,
                             logic [TimeW-1:0] now);
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {now, ident, addr};
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic observe(logic [AddrW-1:0] addr, logic [IdentW-1:0] ident,
                         logic [TimeW-1:0] now);
    send_fields(pdt_pkg::KindObserve, addr, ident, now);
  endtask

  // Address and identity carry junk on a tick; the block must ignore them.
  task automatic tick(logic [TimeW-1:0] now);
    send_fields(pdt_pkg::KindTick, rand_addr(), rand64(), now);
  endtask

  // Stop offering and wait until every predicted result has come back, then
  // let the sequencer settle before anything is reconfigured.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Random traffic: mostly known peers with advancing time, a share of fresh
  // addresses and ticks, and now and then a jump to an arbitrary time.
  task automatic run_traffic(int unsigned n_items, int unsigned step_max);
    logic             kind;
    logic [AddrW-1:0] addr;
    for (int unsigned k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 39) == 0) clock_now = $urandom;
      else clock_now += $urandom_range(0, step_max);
      kind = ($urandom_range(0, 4) == 0) ? pdt_pkg::KindTick : pdt_pkg::KindObserve;
      if ($urandom_range(0, 4) == 0) addr = rand_addr();
      else addr = peer_pool[$urandom_range(0, PoolSize - 1)];
      send_fields(kind, addr, rand64(), clock_now);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb              = new();
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = 1'b0;
    cfg_wdata_i     = '0;
    calm            = 1'b0;
    hold_off_req    = 1'b0;
    peer_pool[0]    = '0;
    peer_pool[1]    = '1;
    for (int i = 2; i < PoolSize; i++) peer_pool[i] = rand_addr();

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset settings: interval 1000, TTL 3000.
    tick(32'd0);                                   // too early: no prune
    tick(32'd1000);                                // prune an empty table
    observe(peer_pool[0], '0, 32'd1000);           // append, all-zero address
    observe(peer_pool[1], '1, 32'd1001);           // append, all-ones address
    observe(peer_pool[0], 64'd5, 32'd1002);        // refresh slot 0
    for (int i = 2; i < 8; i++)
      observe(peer_pool[i], rand64(), 32'd1010);   // fill the table, equal times
    observe(peer_pool[8], rand64(), 32'd1012);     // evict the oldest
    observe(peer_pool[9], rand64(), 32'd1013);     // evict the next oldest
    observe(peer_pool[10], rand64(), 32'd1014);    // tie: lowest index goes
    tick(32'd1500);                                // inside the interval
    tick(32'd4010);                                // prune, age exactly at TTL survives
    tick(32'd4011);
    observe(peer_pool[4], rand64(), 32'd4500);     // refresh two middle entries
    observe(peer_pool[6], rand64(), 32'd4500);
    tick(32'd5011);                                // drop the rest, compact survivors
    observe(peer_pool[11], rand64(), 32'd5011);    // append after compaction
    observe(rand_addr(), rand64(), 32'hFFFF_FF00); // last-seen just before the wrap
    tick(32'h0000_0100);                           // interval and age across the wrap
    tick(32'h0000_0101);
    clock_now = 32'h0000_0200;
    drain();

    // Default settings; block the sink for a long stretch, and once let the
    // sender wait for every outstanding result mid-phase.
    run_traffic(40, 400);
    hold_off_req = 1'b1;
    run_traffic(40, 400);
    drain();
    run_traffic(30, 400);
    drain();

    // Zero interval and zero TTL: every tick prunes, only same-time entries stay.
    write_reg(pdt_pkg::CfgIdxInterval, 32'd0);
    write_reg(pdt_pkg::CfgIdxTtl, 32'd0);
    run_traffic(100, 3);
    drain();

    // Largest values: a tick prunes only one short of a full wrap after the last pass, and
    // then nothing ages out. Start close to the wrap.
    write_reg(pdt_pkg::CfgIdxInterval, 32'hFFFF_FFFF);
    write_reg(pdt_pkg::CfgIdxTtl, 32'hFFFF_FFFF);
    tick(sb.last_prune - 32'd1);
    clock_now = 32'hFFFF_F000;
    run_traffic(100, 200);
    drain();

    // Random mid-range settings.
    write_reg(pdt_pkg::CfgIdxInterval, $urandom_range(0, 300));
    write_reg(pdt_pkg::CfgIdxTtl, $urandom_range(100, 900));
    run_traffic(110, 150);
    drain();

    // Final phase with no idling on either side.
    calm = 1'b1;
    write_reg(pdt_pkg::CfgIdxInterval, 32'd300);
    write_reg(pdt_pkg::CfgIdxTtl, 32'd1500);
    run_traffic(100, 100);
    drain();

    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
